/* rtl/core/assert_macros.svh */
// Assertion macros shared by the hopscotch cache RTL.
// Each macro expands to one labeled concurrent assertion with a reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/hci_pkg.sv */
// Shared types and constants of the hopscotch cache lookup-and-insert block.
// No dependencies; hci_ifs, hci_ctrl, hci_dpath and the top level import this package.
package hci_pkg;

  localparam int KEY_W             = 64;
  localparam int CTL_W             = 2;
  localparam int TIME_W            = 32;
  localparam int MASK_W            = 32;
  localparam int MASK_IDX_W        = 5;
  localparam int SLOT_OUT_W        = 8;
  localparam int DEF_TABLE_SLOTS   = 256;
  localparam int DEF_NEIGHBOR_SPAN = 32;

  typedef struct packed {
    logic [KEY_W-1:0]  player_key;
    logic [CTL_W-1:0]  controller_index;
    logic [TIME_W-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  was_hit;
    logic                  replaced_live;
    logic                  bad_key;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic mask_rd;
    logic mask_cap;
    logic probe_rd;
    logic probe_eval;
    logic hit_wr;
    logic vic_init;
    logic vic_step;
    logic vic_wr;
    logic vmask_rd;
    logic vmask_wr;
    logic clr_step;
    logic res_bad;
    logic res_hit;
    logic res_miss;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic key_zero;
    logic scan_empty;
    logic probe_hit;
    logic vic_done;
    logic vic_at_home;
    logic clr_done;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/hci_ifs.sv */
// Request and response channel interfaces of the hopscotch cache.
// Depends on hci_pkg for the payload types.
interface hci_req_if import hci_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface hci_rsp_if import hci_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/hci_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module hci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/hci_ctrl.sv */
// Controller state machine of the hopscotch cache.
// Depends on hci_pkg; drives the datapath through cmd_t and reads sts_t.
module hci_ctrl import hci_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    ST_CLR    = 13'b0000000000001,
    ST_IDLE   = 13'b0000000000010,
    ST_MRD    = 13'b0000000000100,
    ST_MWAIT  = 13'b0000000001000,
    ST_SCAN   = 13'b0000000010000,
    ST_PWAIT  = 13'b0000000100000,
    ST_VSCAN  = 13'b0000001000000,
    ST_VWR    = 13'b0000010000000,
    ST_VMRD   = 13'b0000100000000,
    ST_VMWAIT = 13'b0001000000000,
    ST_VMWR   = 13'b0010000000000,
    ST_RESULT = 13'b0100000000000,
    ST_SPARE  = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          if (sts.key_zero) begin
            cmd.res_bad = 1'b1;
            state_next  = ST_RESULT;
          end else begin
            state_next = ST_MRD;
          end
        end
      end
      ST_MRD: begin
        cmd.mask_rd = 1'b1;
        state_next  = ST_MWAIT;
      end
      ST_MWAIT: begin
        cmd.mask_cap = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_empty) begin
          cmd.vic_init = 1'b1;
          state_next   = ST_VSCAN;
        end else begin
          cmd.probe_rd = 1'b1;
          state_next   = ST_PWAIT;
        end
      end
      ST_PWAIT: begin
        if (sts.probe_hit) begin
          cmd.hit_wr  = 1'b1;
          cmd.res_hit = 1'b1;
          state_next  = ST_RESULT;
        end else begin
          cmd.probe_eval = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_VSCAN: begin
        if (sts.vic_done) begin
          state_next = ST_VWR;
        end else begin
          cmd.vic_step = 1'b1;
        end
      end
      ST_VWR: begin
        cmd.vic_wr   = 1'b1;
        cmd.res_miss = 1'b1;
        state_next   = sts.vic_at_home ? ST_RESULT : ST_VMRD;
      end
      ST_VMRD: begin
        cmd.vmask_rd = 1'b1;
        state_next   = ST_VMWAIT;
      end
      ST_VMWAIT: begin
        cmd.vmask_rd = 1'b1;
        state_next   = ST_VMWR;
      end
      ST_VMWR: begin
        cmd.vmask_wr = 1'b1;
        state_next   = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLR;
      end
    endcase
  end

endmodule

/* rtl/core/hci_dpath.sv */
// Datapath of the hopscotch cache: slot and mask memories, scan and victim logic.
// Depends on hci_pkg and hci_ram; controlled by hci_ctrl through cmd_t and sts_t.
module hci_dpath import hci_pkg::*; #(
  parameter int TABLE_SLOTS   = DEF_TABLE_SLOTS,
  parameter int NEIGHBOR_SPAN = DEF_NEIGHBOR_SPAN
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output sts_t sts,
  input  req_t req_data,
  input  logic out_ready,
  output logic out_valid,
  output rsp_t out_data
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int OFF_W = $clog2(NEIGHBOR_SPAN);
  localparam int CNT_W = OFF_W + 1;
  localparam int ENT_W = KEY_W + CTL_W + IDX_W + TIME_W;

  logic [KEY_W-1:0]         key_q;
  logic [CTL_W-1:0]         ctl_q;
  logic [TIME_W-1:0]        now_q;
  logic [IDX_W-1:0]         home_q;
  logic [MASK_W-1:0]        mask_cur;
  logic [NEIGHBOR_SPAN-1:0] scan;
  logic [OFF_W-1:0]         probe_off;
  logic [CNT_W-1:0]         vcnt;
  logic                     vpend;
  logic [OFF_W-1:0]         voff;
  logic [OFF_W-1:0]         best_off;
  logic [TIME_W-1:0]        best_time;
  logic                     found_empty;
  logic                     vdone;
  logic [IDX_W-1:0]         clr_cnt;
  logic [IDX_W-1:0]         res_slot;
  logic                     res_hit;
  logic                     res_live;
  logic                     res_bad;

  logic [IDX_W-1:0]  s_addr, m_addr;
  logic              s_we, m_we;
  logic [ENT_W-1:0]  s_wdata, s_rdata;
  logic [MASK_W-1:0] m_wdata, m_rdata;

  logic [KEY_W-1:0]  ent_key;
  logic [CTL_W-1:0]  ent_ctl;
  logic [IDX_W-1:0]  ent_home;
  logic [TIME_W-1:0] ent_touch;
  logic [OFF_W-1:0]  top_off;
  logic [IDX_W-1:0]  home_in;
  logic [IDX_W-1:0]  vic_addr;
  logic [IDX_W-1:0]  probe_addr;

  hci_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_SLOTS)) u_slot_ram (
    .clk   (clk),
    .addr  (s_addr),
    .we    (s_we),
    .wdata (s_wdata),
    .rdata (s_rdata)
  );

  hci_ram #(.WIDTH(MASK_W), .DEPTH(TABLE_SLOTS)) u_mask_ram (
    .clk   (clk),
    .addr  (m_addr),
    .we    (m_we),
    .wdata (m_wdata),
    .rdata (m_rdata)
  );

  assign ent_key    = s_rdata[ENT_W-1 -: KEY_W];
  assign ent_ctl    = s_rdata[IDX_W+TIME_W +: CTL_W];
  assign ent_home   = s_rdata[TIME_W +: IDX_W];
  assign ent_touch  = s_rdata[TIME_W-1:0];
  assign home_in    = IDX_W'(req_data.player_key[31:0] ^ req_data.player_key[63:32]);
  assign vic_addr   = home_q + IDX_W'(best_off);
  assign probe_addr = home_q + IDX_W'(probe_off);

  // Highest pending neighborhood bit.
  always_comb begin
    top_off = '0;
    for (int i = 0; i < NEIGHBOR_SPAN; i++) begin
      if (scan[i]) begin
        top_off = OFF_W'(i);
      end
    end
  end

  always_comb begin
    s_addr  = home_q + IDX_W'(top_off);
    s_we    = 1'b0;
    s_wdata = '0;
    if (cmd.clr_step) begin
      s_addr = clr_cnt;
      s_we   = 1'b1;
    end else if (cmd.hit_wr) begin
      s_addr  = probe_addr;
      s_we    = 1'b1;
      s_wdata = {key_q, ctl_q, ent_home, now_q};
    end else if (cmd.vic_step) begin
      s_addr = home_q + IDX_W'(vcnt[OFF_W-1:0]);
    end else if (cmd.vic_wr) begin
      s_addr  = vic_addr;
      s_we    = 1'b1;
      s_wdata = {key_q, ctl_q, home_q, now_q};
    end
  end

  always_comb begin
    m_addr  = home_q;
    m_we    = 1'b0;
    m_wdata = '0;
    if (cmd.clr_step) begin
      m_addr = clr_cnt;
      m_we   = 1'b1;
    end else if (cmd.hit_wr) begin
      m_we    = 1'b1;
      m_wdata = mask_cur;
    end else if (cmd.vic_wr) begin
      m_we    = 1'b1;
      m_wdata = mask_cur | (MASK_W'(1) << best_off);
    end else if (cmd.vmask_rd) begin
      m_addr = vic_addr;
    end else if (cmd.vmask_wr) begin
      m_addr  = vic_addr;
      m_we    = 1'b1;
      m_wdata = m_rdata & ~MASK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      key_q  <= req_data.player_key;
      ctl_q  <= req_data.controller_index;
      now_q  <= req_data.now_time;
      home_q <= home_in;
    end
    if (cmd.mask_cap) begin
      mask_cur <= m_rdata;
      scan     <= m_rdata[NEIGHBOR_SPAN-1:0];
    end
    if (cmd.probe_rd) begin
      probe_off <= top_off;
    end
    if (cmd.probe_eval) begin
      scan[probe_off] <= 1'b0;
      if (ent_home != home_q) begin
        mask_cur[MASK_IDX_W'(probe_off)] <= 1'b0;
      end
    end
    if (cmd.vic_init) begin
      best_off    <= '0;
      found_empty <= 1'b0;
    end else if (cmd.vic_step && vpend) begin
      if (ent_key == '0) begin
        best_off    <= voff;
        found_empty <= 1'b1;
      end else if (voff == '0 || ent_touch < best_time) begin
        best_off  <= voff;
        best_time <= ent_touch;
      end
    end
    if (cmd.res_bad) begin
      res_slot <= '0;
      res_hit  <= 1'b0;
      res_live <= 1'b0;
      res_bad  <= 1'b1;
    end else if (cmd.res_hit) begin
      res_slot <= probe_addr;
      res_hit  <= 1'b1;
      res_live <= 1'b0;
      res_bad  <= 1'b0;
    end else if (cmd.res_miss) begin
      res_slot <= vic_addr;
      res_hit  <= 1'b0;
      res_live <= !found_empty;
      res_bad  <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data.slot_index    <= SLOT_OUT_W'(res_slot);
      out_data.was_hit       <= res_hit;
      out_data.replaced_live <= res_live;
      out_data.bad_key       <= res_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt      <= '0;
      vpend     <= 1'b0;
      voff      <= '0;
      vdone     <= 1'b0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.vic_init) begin
        vcnt  <= '0;
        vpend <= 1'b0;
        vdone <= 1'b0;
      end else if (cmd.vic_step) begin
        if (vpend && (ent_key == '0 || voff == OFF_W'(NEIGHBOR_SPAN - 1))) begin
          vdone <= 1'b1;
        end
        if (vcnt < CNT_W'(NEIGHBOR_SPAN)) begin
          vpend <= 1'b1;
          voff  <= vcnt[OFF_W-1:0];
          vcnt  <= vcnt + 1'b1;
        end else begin
          vpend <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.key_zero    = (req_data.player_key == '0);
  assign sts.scan_empty  = (scan == '0);
  assign sts.probe_hit   = (ent_ctl == ctl_q) && (ent_key == key_q);
  assign sts.vic_done    = vdone;
  assign sts.vic_at_home = (best_off == '0);
  assign sts.clr_done    = (clr_cnt == IDX_W'(TABLE_SLOTS - 1));
  assign sts.out_free    = !out_valid || out_ready;

endmodule

/* rtl/core/hopscotch_cache_lookup_insert.sv */
// Hopscotch cache lookup-and-insert block with oldest-entry replacement.
// Channels: req (sink) brings player_key, controller_index and now_time; rsp
// (source) returns slot_index, was_hit, replaced_live and bad_key, one
// response per request, in order. Both use valid/ready; a request is taken
// when valid and ready are high at a clock edge.
// One request is processed at a time. A zero key goes from the cycle that
// takes the request straight to ST_RESULT. Otherwise the mask is read (MRD,
// MWAIT) and each neighborhood probe takes a read and a check (SCAN, PWAIT)
// on the single-port slot memory, until a hit or an empty scan. A miss runs
// a pipelined victim search over the neighborhood, writes the victim slot
// and, if the victim is not at the home slot, updates a mask (VMRD, VMWAIT,
// VMWR). The response is loaded in ST_RESULT and is valid on the next cycle.
// After reset both memories are swept to zero, one slot per cycle, while
// req.ready stays low.
// A response waits in an output register while rsp.ready is low; the next
// request can be taken and processed meanwhile, but its own response holds
// until the register frees up.
// TABLE_SLOTS must be a power of two.
// Depends on hci_pkg, hci_ifs, hci_ram, hci_ctrl, hci_dpath and assert_macros.svh.
`include "assert_macros.svh"

module hopscotch_cache_lookup_insert import hci_pkg::*; #(
  parameter int TABLE_SLOTS   = DEF_TABLE_SLOTS,
  parameter int NEIGHBOR_SPAN = DEF_NEIGHBOR_SPAN
) (
  input logic       clk,
  input logic       rst,
  hci_req_if.sink   req,
  hci_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;
  logic bad_key_dirty;

  hci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hci_dpath #(
    .TABLE_SLOTS   (TABLE_SLOTS),
    .NEIGHBOR_SPAN (NEIGHBOR_SPAN)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req.data),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .out_data  (rsp.data)
  );

  assign bad_key_dirty = rsp.data.was_hit || rsp.data.replaced_live ||
                         (rsp.data.slot_index != '0);

  `ASSERT_NEVER(a_bad_key_clean, clk, rst, rsp.valid && rsp.data.bad_key && bad_key_dirty, "Zero-key response carries other flags.")
  `ASSERT_NEVER(a_hit_not_replace, clk, rst, rsp.valid && rsp.data.was_hit && rsp.data.replaced_live, "Hit response also reports a replacement.")
  `ASSERT_NEXT(a_busy_after_req, clk, rst, req.valid && req.ready, !req.ready, "Request taken while the previous one is still in progress.")

endmodule
